@@ hw/rtl/stq_pkg.sv @@
// Types, codes and helpers shared by the timer queue modules.
package stq_pkg;

	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ACT_AFTER    = 3'd0,
		ACT_PERIODIC = 3'd1,
		ACT_AT       = 3'd2,
		ACT_CANCEL   = 3'd3,
		ACT_CANCEL_ALL = 3'd4,
		ACT_TICK     = 3'd5,
		ACT_RESET    = 3'd6,
		ACT_QUERY    = 3'd7
	} stq_action_t;

	localparam logic [1:0] KIND_SCHED  = 2'd0;
	localparam logic [1:0] KIND_REPLY  = 2'd1;
	localparam logic [1:0] KIND_FIRED  = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_FULL       = 2'd1;
	localparam logic [1:0] ST_NOT_ACTIVE = 2'd2;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] time_value;
		logic [31:0] task_id;
	} stq_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] fired_or_new_id;
		logic [1:0]  status;
		logic [31:0] now_time;
		logic [31:0] soonest_fire;
		logic        soonest_valid;
		logic [4:0]  pending_count;
		logic        last;
	} stq_out_t;

	typedef enum logic [1:0] {
		SCAN_MATCH = 2'd0,
		SCAN_BEST  = 2'd1,
		SCAN_SUM   = 2'd2
	} stq_scan_t;

	typedef struct packed {
		logic      accept;
		logic      sched;
		logic      step;
		stq_scan_t mode;
		logic      pop;
		logic      fifo_rd;
		logic      load_fired;
		logic      load_last;
	} stq_cmd_t;

	typedef struct packed {
		logic [2:0] action;
		logic       paused;
		logic       scan_end;
		logic       best_valid;
		logic       fifo_empty;
		logic       out_free;
	} stq_stat_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? TIME_MAX : s[31:0];
	endfunction

endpackage

@@ hw/rtl/software_timer_queue.sv @@
// Top level of the timer queue: sequencer, datapath and checks.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_data (stq_in_t)
//  out     | output    | out_valid / out_ready | out_data (stq_out_t)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data (paused)
//
// One item at a time. Schedule: slot write, then summary scan. Cancel and
// query: match scan of all slots, then summary scan. An unpaused tick runs
// one round per popped slot plus one empty round, then a summary scan, and
// emits each fired result from the queue. Reset clears all control state at
// once; no sweep. Stalls on out only hold the sequencer in its emit states.
module software_timer_queue
	import stq_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  stq_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output stq_out_t out_data,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic     cfg_data
);

	stq_cmd_t  cmd;
	stq_stat_t stat;

	assign cfg_ready = 1'b1;

	stq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	stq_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a transaction while busy");
	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_FIRED |-> !out_data.last)
		else $error("fired result flagged last");
	a_fired_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_FIRED |-> out_data.status == ST_OK)
		else $error("fired result with non-zero status");
`endif

endmodule

@@ hw/rtl/stq_ctrl.sv @@
// Sequencer for the timer queue: decodes commands and steps the slot scans.
module stq_ctrl
	import stq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  stq_stat_t stat,
	output stq_cmd_t  cmd
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_DISP  = 10'b00_0000_0010,
		S_EXEC  = 10'b00_0000_0100,
		S_MATCH = 10'b00_0000_1000,
		S_ROUND = 10'b00_0001_0000,
		S_POP   = 10'b00_0010_0000,
		S_SUMS  = 10'b00_0100_0000,
		S_RDF   = 10'b00_1000_0000,
		S_EMIT  = 10'b01_0000_0000,
		S_LAST  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.mode = SCAN_SUM;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (stat.action)
					ACT_AFTER, ACT_PERIODIC, ACT_AT: state_d = S_EXEC;
					ACT_CANCEL, ACT_QUERY:           state_d = S_MATCH;
					ACT_TICK:                        state_d = stat.paused ? S_SUMS : S_ROUND;
					default:                         state_d = S_SUMS;
				endcase
			end
			S_EXEC: begin
				cmd.sched = 1'b1;
				state_d = S_SUMS;
			end
			S_MATCH: begin
				cmd.step = 1'b1;
				cmd.mode = SCAN_MATCH;
				if (stat.scan_end) state_d = S_SUMS;
			end
			S_ROUND: begin
				cmd.step = 1'b1;
				cmd.mode = SCAN_BEST;
				if (stat.scan_end) state_d = S_POP;
			end
			S_POP: begin
				// pop the best due slot; with nothing due left, this tick is finished
				cmd.pop = 1'b1;
				state_d = stat.best_valid ? S_ROUND : S_SUMS;
			end
			S_SUMS: begin
				cmd.step = 1'b1;
				if (stat.scan_end) state_d = stat.fifo_empty ? S_LAST : S_RDF;
			end
			S_RDF: begin
				cmd.fifo_rd = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.load_fired = 1'b1;
					state_d = stat.fifo_empty ? S_LAST : S_RDF;
				end
			end
			S_LAST: begin
				if (stat.out_free) begin
					cmd.load_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ hw/rtl/stq_datapath.sv @@
// Slot table, clock, id counter, fired-id queue and output register.
module stq_datapath
	import stq_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  stq_in_t   in_data,
	input  logic      cfg_valid,
	input  logic      cfg_data,
	input  stq_cmd_t  cmd,
	output stq_stat_t stat,
	output logic      out_valid,
	input  logic      out_ready,
	output stq_out_t  out_data
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PW = $clog2(CAPACITY + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

	logic [CAPACITY-1:0] held_q, active_q, done_q;
	logic [31:0] ident_q  [CAPACITY];
	logic [31:0] fire_q   [CAPACITY];
	logic [31:0] period_q [CAPACITY];
	logic [31:0] fifo_q   [CAPACITY];

	logic [31:0] now_q, id_q, tv_q, tid_q;
	logic [2:0]  act_q;
	logic        paused_q;
	logic [IW-1:0] idx_q, bidx_q;
	logic        found_q, bv_q;
	logic [31:0] bf_q, bid_q;
	logic [PW-1:0] wr_q, rd_q;
	logic [31:0] rd_data_q;
	logic [1:0]  rep_kind_q, rep_st_q;
	logic [31:0] rep_id_q;
	logic [31:0] soon_q;
	logic        sv_q;
	logic [4:0]  pend_q;
	logic        out_valid_q;
	stq_out_t    out_q;

	logic          free_any;
	logic [IW-1:0] free_idx;
	logic [31:0]   cur_fire, cur_id, cur_period, new_fire, next_id;
	logic [31:0]   rearm_a, rearm_b;
	logic          cur_match, cur_due, cur_better, out_free;
	logic [1:0]    last_st;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!held_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign cur_fire   = fire_q[idx_q];
	assign cur_id     = ident_q[idx_q];
	assign cur_period = period_q[bidx_q];
	assign cur_match  = held_q[idx_q] && active_q[idx_q] && (cur_id == tid_q);
	assign cur_due    = held_q[idx_q] && !done_q[idx_q] && (cur_fire <= now_q);
	assign cur_better = !bv_q || (cur_fire < bf_q) || ((cur_fire == bf_q) && (cur_id < bid_q));
	assign new_fire   = (act_q == ACT_AT) ? tv_q : sat_add(now_q, tv_q);
	assign next_id    = (id_q == TIME_MAX) ? 32'd1 : id_q + 32'd1;
	assign rearm_a    = sat_add(bf_q, cur_period);
	assign rearm_b    = sat_add(now_q, cur_period);
	assign out_free   = !out_valid_q || out_ready;
	assign last_st    = (rep_kind_q == KIND_REPLY) ? (found_q ? ST_OK : ST_NOT_ACTIVE)
	                                                : rep_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			active_q    <= '0;
			done_q      <= '0;
			now_q       <= '0;
			id_q        <= 32'd1;
			paused_q    <= 1'b0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			bv_q        <= 1'b0;
			wr_q        <= '0;
			rd_q        <= '0;
			sv_q        <= 1'b0;
			pend_q      <= '0;
			soon_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) paused_q <= cfg_data;
			if (cmd.accept) begin
				done_q  <= '0;
				idx_q   <= '0;
				found_q <= 1'b0;
				bv_q    <= 1'b0;
				wr_q    <= '0;
				rd_q    <= '0;
				sv_q    <= 1'b0;
				pend_q  <= '0;
				soon_q  <= '0;
				if (in_data.action == ACT_CANCEL_ALL || in_data.action == ACT_RESET) begin
					held_q   <= '0;
					active_q <= '0;
				end
				if (in_data.action == ACT_RESET) begin
					now_q <= '0;
					id_q  <= 32'd1;
				end
				if (in_data.action == ACT_TICK && !paused_q)
					now_q <= sat_add(now_q, in_data.time_value);
			end
			if (cmd.sched && free_any) begin
				held_q[free_idx]   <= 1'b1;
				active_q[free_idx] <= 1'b1;
				id_q <= next_id;
			end
			if (cmd.step) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
				unique case (cmd.mode)
					SCAN_MATCH: begin
						if (cur_match) begin
							found_q <= 1'b1;
							// cancel drops only the first matching slot
							if (act_q == ACT_CANCEL && !found_q) active_q[idx_q] <= 1'b0;
						end
					end
					SCAN_BEST: begin
						if (cur_due && cur_better) bv_q <= 1'b1;
					end
					default: begin
						if (held_q[idx_q]) begin
							sv_q <= 1'b1;
							if (!sv_q || cur_fire < soon_q) soon_q <= cur_fire;
						end
						if (active_q[idx_q]) pend_q <= pend_q + 5'd1;
					end
				endcase
			end
			if (cmd.pop && bv_q) begin
				bv_q <= 1'b0;
				done_q[bidx_q] <= 1'b1;
				if (!active_q[bidx_q]) begin
					held_q[bidx_q] <= 1'b0;
				end else begin
					wr_q <= wr_q + 1'b1;
					if (cur_period == 32'd0) begin
						held_q[bidx_q]   <= 1'b0;
						active_q[bidx_q] <= 1'b0;
					end
				end
			end
			if (cmd.fifo_rd) rd_q <= rd_q + 1'b1;
			if (cmd.load_fired || cmd.load_last) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q    <= in_data.action;
			tv_q     <= in_data.time_value;
			tid_q    <= in_data.task_id;
			rep_st_q <= ST_OK;
			unique case (in_data.action)
				ACT_AFTER, ACT_PERIODIC, ACT_AT: begin
					rep_kind_q <= KIND_SCHED;
					rep_id_q   <= '0;
				end
				ACT_CANCEL, ACT_QUERY: begin
					rep_kind_q <= KIND_REPLY;
					rep_id_q   <= in_data.task_id;
				end
				default: begin
					rep_kind_q <= KIND_STATUS;
					rep_id_q   <= '0;
				end
			endcase
		end
		if (cmd.sched) begin
			if (free_any) begin
				ident_q[free_idx]  <= id_q;
				fire_q[free_idx]   <= new_fire;
				period_q[free_idx] <= (act_q == ACT_PERIODIC) ? tv_q : 32'd0;
				rep_id_q <= id_q;
			end else begin
				rep_st_q <= ST_FULL;
			end
		end
		if (cmd.step && cmd.mode == SCAN_BEST && cur_due && cur_better) begin
			bf_q   <= cur_fire;
			bid_q  <= cur_id;
			bidx_q <= idx_q;
		end
		if (cmd.pop && bv_q && active_q[bidx_q]) begin
			fifo_q[wr_q[IW-1:0]] <= bid_q;
			if (cur_period != 32'd0)
				fire_q[bidx_q] <= (rearm_a <= now_q) ? rearm_b : rearm_a;
		end
		if (cmd.fifo_rd) rd_data_q <= fifo_q[rd_q[IW-1:0]];
		if (cmd.load_fired) begin
			out_q <= '{kind: KIND_FIRED, fired_or_new_id: rd_data_q, status: ST_OK,
			           now_time: now_q, soonest_fire: soon_q, soonest_valid: sv_q,
			           pending_count: pend_q, last: 1'b0};
		end
		if (cmd.load_last) begin
			out_q <= '{kind: rep_kind_q, fired_or_new_id: rep_id_q, status: last_st,
			           now_time: now_q, soonest_fire: soon_q, soonest_valid: sv_q,
			           pending_count: pend_q, last: 1'b1};
		end
	end

	assign stat = '{action: act_q, paused: paused_q, scan_end: (idx_q == LAST_IDX),
	                best_valid: bv_q, fifo_empty: (rd_q == wr_q), out_free: out_free};
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
